// ===== src/tmcs_pkg.sv =====
// Shared types, constants and the format decode for the texture mip chain size unit.
// Used by the channel interfaces, the level cell and the top level.
package tmcs_pkg;

  localparam int DIM_BITS   = 16;
  localparam int MAX_LEVELS = 32;

  localparam int FMT_W     = 4;
  localparam int CNT_W     = 5;
  localparam int TOTAL_W   = 35;
  localparam int BLK_LOG_W = 2;
  localparam int BYTE_LOG_W = 3;
  localparam int MASK_W    = 3;

  // Block counts need one bit beyond the dimension for the round-up carry.
  localparam int BLK_W = DIM_BITS + 1;
  localparam int MUL_W = 2 * BLK_W;
  localparam int PW    = (MUL_W + 4 > TOTAL_W) ? MUL_W + 4 : TOTAL_W;

  localparam logic [FMT_W-1:0] FMT_R8      = 4'd0;
  localparam logic [FMT_W-1:0] FMT_RG8     = 4'd1;
  localparam logic [FMT_W-1:0] FMT_R16SINT = 4'd2;
  localparam logic [FMT_W-1:0] FMT_RGBA8   = 4'd3;
  localparam logic [FMT_W-1:0] FMT_BGRA8   = 4'd4;
  localparam logic [FMT_W-1:0] FMT_R32F    = 4'd5;
  localparam logic [FMT_W-1:0] FMT_BC1     = 4'd6;
  localparam logic [FMT_W-1:0] FMT_BC3     = 4'd7;
  localparam logic [FMT_W-1:0] FMT_BC5     = 4'd8;
  localparam logic [FMT_W-1:0] FMT_BC7     = 4'd9;
  localparam logic [FMT_W-1:0] FMT_ASTC4   = 4'd10;
  localparam logic [FMT_W-1:0] FMT_ASTC8   = 4'd11;

  typedef struct packed {
    logic [BLK_LOG_W-1:0]  bw_log2;
    logic [BLK_LOG_W-1:0]  bh_log2;
    logic [BYTE_LOG_W-1:0] bytes_log2;
    logic                  compressed;
    logic                  bad;
  } fmt_t;

  // One item in flight along the chain of level cells.
  typedef struct packed {
    logic                  valid;
    logic [DIM_BITS-1:0]   w;
    logic [DIM_BITS-1:0]   h;
    logic [CNT_W-1:0]      rem;
    logic [BLK_LOG_W-1:0]  bw_log2;
    logic [BLK_LOG_W-1:0]  bh_log2;
    logic [BYTE_LOG_W-1:0] bytes_log2;
    logic [TOTAL_W-1:0]    prod;
    logic [TOTAL_W-1:0]    total;
    logic                  aligned;
    logic                  bad;
  } beat_t;

  function automatic fmt_t fmt_lookup(input logic [FMT_W-1:0] code);
    fmt_t f;
    f = '0;
    unique case (code) inside
      FMT_R8: begin
        f.bytes_log2 = 3'd0;
      end
      FMT_RG8, FMT_R16SINT: begin
        f.bytes_log2 = 3'd1;
      end
      FMT_RGBA8, FMT_BGRA8, FMT_R32F: begin
        f.bytes_log2 = 3'd2;
      end
      FMT_BC1: begin
        f.bw_log2    = 2'd2;
        f.bh_log2    = 2'd2;
        f.bytes_log2 = 3'd3;
        f.compressed = 1'b1;
      end
      FMT_BC3, FMT_BC5, FMT_BC7, FMT_ASTC4: begin
        f.bw_log2    = 2'd2;
        f.bh_log2    = 2'd2;
        f.bytes_log2 = 3'd4;
        f.compressed = 1'b1;
      end
      FMT_ASTC8: begin
        f.bw_log2    = 2'd3;
        f.bh_log2    = 2'd3;
        f.bytes_log2 = 3'd4;
        f.compressed = 1'b1;
      end
      default: begin
        f.bad = 1'b1;
      end
    endcase
    return f;
  endfunction

  function automatic logic [MASK_W-1:0] blk_mask(input logic [BLK_LOG_W-1:0] lg);
    return MASK_W'((4'd1 << lg) - 4'd1);
  endfunction

endpackage

// ===== src/tmcs_if.sv =====
// Valid/ready channels of the texture mip chain size unit: query in, size out.
// Depends on tmcs_pkg for field widths.
interface tmcs_in_if;
  import tmcs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FMT_W-1:0]      fmt_code;
  logic [DIM_BITS-1:0]   base_width;
  logic [DIM_BITS-1:0]   base_height;
  logic [CNT_W-1:0]      level_count;

  modport source (output valid, fmt_code, base_width, base_height, level_count,
                  input ready);
  modport sink   (input valid, fmt_code, base_width, base_height, level_count,
                  output ready);
endinterface

interface tmcs_out_if;
  import tmcs_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_bytes;
  logic               aligned;
  logic               bad_format;

  modport source (output valid, total_bytes, aligned, bad_format, input ready);
  modport sink   (input valid, total_bytes, aligned, bad_format, output ready);
endinterface

// ===== src/tmcs_cell.sv =====
// One mip level cell: sizes its level, adds the previous level's bytes, halves the dims.
// Depends on tmcs_pkg.
module tmcs_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  tmcs_pkg::beat_t beat_i,
  output tmcs_pkg::beat_t beat_o
);
  import tmcs_pkg::*;

  logic [DIM_BITS-1:0] dim_w;
  logic [DIM_BITS-1:0] dim_h;
  logic [BLK_W-1:0]    blk_w;
  logic [BLK_W-1:0]    blk_h;
  logic [MUL_W-1:0]    mul;
  logic [PW-1:0]       scaled;
  logic                lvl_en;
  logic                valid_q;
  beat_t               beat_d;
  beat_t               beat_q;

  always_comb begin
    // Clamp each level dimension to at least one texel.
    dim_w  = (beat_i.w == '0) ? DIM_BITS'(1) : beat_i.w;
    dim_h  = (beat_i.h == '0) ? DIM_BITS'(1) : beat_i.h;
    blk_w  = (BLK_W'(dim_w) + BLK_W'(blk_mask(beat_i.bw_log2))) >> beat_i.bw_log2;
    blk_h  = (BLK_W'(dim_h) + BLK_W'(blk_mask(beat_i.bh_log2))) >> beat_i.bh_log2;
    mul    = blk_w * blk_h;
    scaled = PW'(mul) << beat_i.bytes_log2;
    lvl_en = (beat_i.rem != '0) && !beat_i.bad;

    beat_d         = beat_i;
    beat_d.w       = beat_i.w >> 1;
    beat_d.h       = beat_i.h >> 1;
    beat_d.rem     = beat_i.rem - CNT_W'(beat_i.rem != '0);
    beat_d.prod    = lvl_en ? scaled[TOTAL_W-1:0] : '0;
    beat_d.total   = beat_i.total + beat_i.prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= beat_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      beat_q <= beat_d;
    end
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

// ===== src/texture_mip_chain_size_unit.sv =====
// Mip chain byte size: a row of MAX_LEVELS level cells, one per mip level, followed by an
// output register. A query moves one cell per cycle while the row is not stalled, and its
// result is registered after the last cell; the row is a pipeline and takes a new query every cycle
// the output is free or being taken. Depends on tmcs_pkg, tmcs_if and tmcs_cell.
module texture_mip_chain_size_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  tmcs_in_if.sink       in_i,
  tmcs_out_if.source    out_o
);
  import tmcs_pkg::*;

  fmt_t               fmt;
  beat_t              head;
  beat_t              chain [MAX_LEVELS+1];
  logic               advance;
  logic               w_fit;
  logic               h_fit;
  logic               out_valid_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic               out_aligned_q;
  logic               out_bad_q;

  // The whole row moves together; stall it while a result waits.
  assign advance = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;

  always_comb begin
    fmt   = fmt_lookup(in_i.fmt_code);
    w_fit = (in_i.base_width[MASK_W-1:0] & blk_mask(fmt.bw_log2)) == '0;
    h_fit = (in_i.base_height[MASK_W-1:0] & blk_mask(fmt.bh_log2)) == '0;

    head.valid      = in_i.valid;
    head.w          = in_i.base_width;
    head.h          = in_i.base_height;
    head.rem        = in_i.level_count;
    head.bw_log2    = fmt.bw_log2;
    head.bh_log2    = fmt.bh_log2;
    head.bytes_log2 = fmt.bytes_log2;
    head.prod       = '0;
    head.total      = '0;
    head.bad        = fmt.bad;
    head.aligned    = !fmt.bad && (in_i.base_width != '0) && (in_i.base_height != '0)
                      && (!fmt.compressed || (w_fit && h_fit));
  end

  assign chain[0] = head;

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
    tmcs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .beat_i    (chain[g]),
      .beat_o    (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= chain[MAX_LEVELS].valid;
    end
  end

  // Fold in the last level's bytes.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_total_q   <= chain[MAX_LEVELS].total + chain[MAX_LEVELS].prod;
      out_aligned_q <= chain[MAX_LEVELS].aligned;
      out_bad_q     <= chain[MAX_LEVELS].bad;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.total_bytes = out_total_q;
  assign out_o.aligned     = out_aligned_q;
  assign out_o.bad_format  = out_bad_q;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bad_q |-> (out_total_q == '0) && !out_aligned_q)
    else $error("bad format beat carries a nonzero size or aligned flag");

  a_rose_from_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(chain[MAX_LEVELS].valid))
    else $error("result appeared without a beat leaving the last cell");

  a_stall_holds_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(chain[MAX_LEVELS].valid) && $stable(chain[1].valid))
    else $error("cell row moved during an output stall");

endmodule

// ===== tb/sv/tb_texture_mip_chain_size_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for texture_mip_chain_size_unit: directed and random size queries,
// each predicted here and compared against the size beat that comes back.
// Depends on tmcs_pkg, tmcs_if and the unit's RTL.
module tb_texture_mip_chain_size_unit;
  import tmcs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_QUERIES = 1250;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               aligned;
    logic               bad;
  } chain_size_t;

  logic clk_i;
  logic rst_ni;

  tmcs_in_if  query_if ();
  tmcs_out_if size_if ();

  chain_size_t pending_sizes_q[$];
  int          err_cnt;
  int          stall_cnt;
  bit          idle_on;

  texture_mip_chain_size_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (query_if),
    .out_o  (size_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Byte size of the chain and the alignment flag for one query.
  function automatic chain_size_t predict_chain_size(input logic [FMT_W-1:0] code,
                                                     input logic [DIM_BITS-1:0] w,
                                                     input logic [DIM_BITS-1:0] h,
                                                     input logic [CNT_W-1:0] levels);
    chain_size_t r;
    int unsigned blk_side;
    int unsigned blk_bytes;
    bit          packed_fmt;
    longint unsigned lw, lh, nbw, nbh;
    int          last;
    r = '0;
    case (code)
      FMT_R8: begin
        blk_side = 1; blk_bytes = 1; packed_fmt = 1'b0;
      end
      FMT_RG8, FMT_R16SINT: begin
        blk_side = 1; blk_bytes = 2; packed_fmt = 1'b0;
      end
      FMT_RGBA8, FMT_BGRA8, FMT_R32F: begin
        blk_side = 1; blk_bytes = 4; packed_fmt = 1'b0;
      end
      FMT_BC1: begin
        blk_side = 4; blk_bytes = 8; packed_fmt = 1'b1;
      end
      FMT_BC3, FMT_BC5, FMT_BC7, FMT_ASTC4: begin
        blk_side = 4; blk_bytes = 16; packed_fmt = 1'b1;
      end
      FMT_ASTC8: begin
        blk_side = 8; blk_bytes = 16; packed_fmt = 1'b1;
      end
      default: begin
        r.bad = 1'b1;
        return r;
      end
    endcase
    last = (int'(levels) > MAX_LEVELS) ? MAX_LEVELS : int'(levels);
    for (int lv = 0; lv < last; lv++) begin
      lw = (lv >= 64) ? 0 : (longint'(w) >> lv);
      lh = (lv >= 64) ? 0 : (longint'(h) >> lv);
      if (lw == 0) lw = 1;
      if (lh == 0) lh = 1;
      nbw = (lw + blk_side - 1) / blk_side;
      nbh = (lh + blk_side - 1) / blk_side;
      // Sum wraps at the width of the total.
      r.total = r.total + TOTAL_W'(nbw * nbh * blk_bytes);
    end
    if (w == 0 || h == 0) begin
      r.aligned = 1'b0;
    end else if (!packed_fmt) begin
      r.aligned = 1'b1;
    end else begin
      r.aligned = (w % blk_side == 0) && (h % blk_side == 0);
    end
    return r;
  endfunction

  // Drive one query beat; valid stays high into the next call when no gap is drawn.
  task automatic send_query(input logic [FMT_W-1:0] code, input logic [DIM_BITS-1:0] w,
                            input logic [DIM_BITS-1:0] h, input logic [CNT_W-1:0] levels);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      query_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    query_if.valid       <= 1'b1;
    query_if.fmt_code    <= code;
    query_if.base_width  <= w;
    query_if.base_height <= h;
    query_if.level_count <= levels;
    do @(negedge clk_i); while (!query_if.ready);
    @(posedge clk_i);
    pending_sizes_q.push_back(predict_chain_size(code, w, h, levels));
  endtask

  function automatic logic [DIM_BITS-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return DIM_BITS'($urandom_range(0, 64));
      1: return DIM_BITS'(1) << $urandom_range(0, DIM_BITS - 1);
      2: return DIM_BITS'($urandom_range(1, 8191) * 8);
      3: return ($urandom_range(0, 1) == 0) ? '0 : '1;
      default: return DIM_BITS'($urandom);
    endcase
  endfunction

  task automatic test_each_format();
    idle_on = 1'b0;
    for (int c = 0; c < 16; c++) begin
      send_query(FMT_W'(c), 16'd100, 16'd64, 5'd7);
    end
  endtask

  task automatic test_size_extremes();
    idle_on = 1'b1;
    send_query(FMT_RGBA8, 16'hFFFF, 16'hFFFF, 5'd31);
    send_query(FMT_R8, 16'd0, 16'd0, 5'd0);
    send_query(FMT_BC1, 16'd0, 16'd16, 5'd3);
    send_query(FMT_ASTC8, 16'd64, 16'd64, 5'd31);
    send_query(FMT_ASTC8, 16'd64, 16'd60, 5'd4);
    send_query(FMT_BC7, 16'hFFFF, 16'd1, 5'd31);
    send_query(FMT_R32F, 16'd1, 16'hFFFF, 5'd1);
    send_query(4'd15, 16'hFFFF, 16'hFFFF, 5'd31);
    send_query(FMT_BC3, 16'd16, 16'd16, 5'd0);
  endtask

  task automatic test_random_queries(input int count);
    logic [FMT_W-1:0] code;
    for (int i = 0; i < count; i++) begin
      // Switch idling per stretch so some stretches run back to back.
      if (i % 125 == 0) idle_on = ($urandom_range(0, 3) != 0);
      code = ($urandom_range(0, 9) == 0) ? FMT_W'($urandom_range(12, 15))
                                         : FMT_W'($urandom_range(0, 11));
      send_query(code, pick_dim(), pick_dim(), CNT_W'($urandom_range(0, 31)));
    end
  endtask

  // Take size beats with random stalls and check each against the oldest prediction.
  initial begin
    chain_size_t want;
    int stall;
    size_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        size_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      size_if.ready <= 1'b1;
      do @(negedge clk_i); while (!size_if.valid);
      if (pending_sizes_q.size() == 0) begin
        $error("size beat with no query pending: total_bytes %0d", size_if.total_bytes);
        err_cnt++;
      end else begin
        want = pending_sizes_q.pop_front();
        if (size_if.total_bytes !== want.total) begin
          $error("total_bytes: expected %0d, got %0d", want.total, size_if.total_bytes);
          err_cnt++;
        end
        if (size_if.aligned !== want.aligned) begin
          $error("aligned: expected %0b, got %0b", want.aligned, size_if.aligned);
          err_cnt++;
        end
        if (size_if.bad_format !== want.bad) begin
          $error("bad_format: expected %0b, got %0b", want.bad, size_if.bad_format);
          err_cnt++;
        end
      end
      @(posedge clk_i);
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(negedge clk_i) begin
    if ((query_if.valid && query_if.ready) || (size_if.valid && size_if.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    err_cnt   = 0;
    stall_cnt = 0;
    idle_on   = 1'b0;
    rst_ni               <= 1'b0;
    query_if.valid       <= 1'b0;
    query_if.fmt_code    <= '0;
    query_if.base_width  <= '0;
    query_if.base_height <= '0;
    query_if.level_count <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_each_format();
    test_size_extremes();
    test_random_queries(RANDOM_QUERIES);

    query_if.valid <= 1'b0;
    wait (pending_sizes_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== texture_mip_chain_size_unit.f =====
src/tmcs_pkg.sv
src/tmcs_if.sv
src/tmcs_cell.sv
src/texture_mip_chain_size_unit.sv
tb/sv/tb_texture_mip_chain_size_unit.sv
